// ===== design/tdx_pkg.sv =====
// Shared widths, sequencer phase codes and lane control type for the tracking differentiator.
package tdx_pkg;

   // Field and register widths
   localparam int POS_W   = 32;            // Q15.16 position
   localparam int VEL_W   = 21;            // Q4.16 velocity, signed
   localparam int ACC_A_W = 21;            // Q4.16 clamped acceleration, signed
   localparam int DT_W    = 16;            // Q0.16 time step
   localparam int BW_W    = 22;            // Q6.16 bandwidth
   localparam int BW2_W   = 28;            // Q12.16 bandwidth squared
   localparam int LIM_W   = 20;            // Q4.16 limits
   localparam int FRAC_W  = 16;
   localparam int ERR_W   = POS_W + 1;
   localparam int ERR_HI_W = ERR_W - FRAC_W;

   // Lane multiplier and accumulator
   localparam int MA_W    = BW2_W + 1;
   localparam int MB_W    = VEL_W + 1;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int ACC_W   = 64;
   localparam int STEP_W  = VEL_W + 1;     // (x * dt) >>> 16 for |x| within Q4.16
   localparam int VSUM_W  = VEL_W + 2;
   localparam int PSUM_W  = POS_W + 2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = BW_W;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDWIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIM_XY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIM_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VLIM_XY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VLIM_Z    = 3'd4;

   localparam logic [BW_W-1:0]  BW_RESET      = 22'd90590;
   localparam logic [LIM_W-1:0] ALIM_XY_RESET = 20'd6554;
   localparam logic [LIM_W-1:0] ALIM_Z_RESET  = 20'd5243;
   localparam logic [LIM_W-1:0] VLIM_XY_RESET = 20'd7864;
   localparam logic [LIM_W-1:0] VLIM_Z_RESET  = 20'd6554;

   // Stream payload layout
   localparam int REQ_DATA_W = 112;        // 3 x 32 target + 16 time step
   localparam int RSP_DATA_W = 96;
   localparam int DT_LSB     = 3 * POS_W;

   // Sequencer phases
   localparam int PH_W = 4;
   localparam logic [PH_W-1:0] PH_IDLE = 4'd0;
   localparam logic [PH_W-1:0] PH_ERR  = 4'd1;   // error, bandwidth squared
   localparam logic [PH_W-1:0] PH_MLO  = 4'd2;   // bw2 * error low half
   localparam logic [PH_W-1:0] PH_MHI  = 4'd3;   // bw2 * error high half
   localparam logic [PH_W-1:0] PH_MVB  = 4'd4;   // bw * velocity
   localparam logic [PH_W-1:0] PH_ACC  = 4'd5;   // finish raw acceleration
   localparam logic [PH_W-1:0] PH_CLA  = 4'd6;   // clamp acceleration
   localparam logic [PH_W-1:0] PH_MAD  = 4'd7;   // accel * dt
   localparam logic [PH_W-1:0] PH_VEL  = 4'd8;   // velocity update
   localparam logic [PH_W-1:0] PH_MVD  = 4'd9;   // velocity * dt
   localparam logic [PH_W-1:0] PH_POS  = 4'd10;  // position update
   localparam logic [PH_W-1:0] PH_LOAD = 4'd11;  // snap to target
   localparam logic [PH_W-1:0] PH_OUT  = 4'd12;  // hand positions to output register

   typedef struct packed {
      logic [PH_W-1:0] phase;
      logic            take;     // latch new target
   } lane_ctl_type;

endpackage

// ===== design/tdx_lane.sv =====
// One axis lane: error, acceleration, velocity and position update on a shared multiplier.
module tdx_lane
   import tdx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lane_ctl_type       ctl,
   input  logic [POS_W-1:0]   target,
   input  logic [DT_W-1:0]    dt,
   input  logic [BW_W-1:0]    bw,
   input  logic [BW2_W-1:0]   bw2,
   input  logic [LIM_W-1:0]   alim,
   input  logic [LIM_W-1:0]   vlim,
   output logic [POS_W-1:0]   pos
);

   logic signed [POS_W-1:0]   target_ff, target_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   acc_sh;
   logic signed [ACC_W-1:0]   alim_s;
   logic signed [ACC_A_W-1:0] a_ff, a_in;
   logic signed [VEL_W-1:0]   vel_ff, vel_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [STEP_W-1:0]  step;
   logic signed [VSUM_W-1:0]  vsum, vlim_s;
   logic signed [PSUM_W-1:0]  psum;

   assign step     = prod_ff[FRAC_W+STEP_W-1:FRAC_W];
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_sh   = acc_ff >>> FRAC_W;
   assign alim_s   = $signed({{(ACC_W-LIM_W){1'b0}}, alim});
   assign vlim_s   = $signed({{(VSUM_W-LIM_W){1'b0}}, vlim});
   assign vsum     = {{(VSUM_W-VEL_W){vel_ff[VEL_W-1]}}, vel_ff}
                   + {{(VSUM_W-STEP_W){step[STEP_W-1]}}, step};
   assign psum     = {{(PSUM_W-POS_W){pos_ff[POS_W-1]}}, pos_ff}
                   + {{(PSUM_W-STEP_W){step[STEP_W-1]}}, step};

   // Multiplier operand select
   always_comb begin
      case (ctl.phase)
         PH_MLO: begin
            mul_a = $signed({1'b0, bw2});
            mul_b = $signed({{(MB_W-FRAC_W){1'b0}}, err_ff[FRAC_W-1:0]});
         end
         PH_MHI: begin
            mul_a = $signed({1'b0, bw2});
            mul_b = {{(MB_W-ERR_HI_W){err_ff[ERR_W-1]}}, err_ff[ERR_W-1:FRAC_W]};
         end
         PH_MVB: begin
            mul_a = $signed({{(MA_W-BW_W){1'b0}}, bw});
            mul_b = {vel_ff[VEL_W-1], vel_ff};
         end
         PH_MAD: begin
            mul_a = {{(MA_W-ACC_A_W){a_ff[ACC_A_W-1]}}, a_ff};
            mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt});
         end
         PH_MVD: begin
            mul_a = {{(MA_W-VEL_W){vel_ff[VEL_W-1]}}, vel_ff};
            mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      target_in = ctl.take ? $signed(target) : target_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      vel_in    = vel_ff;
      pos_in    = pos_ff;
      case (ctl.phase)
         PH_ERR: begin
            err_in = {target_ff[POS_W-1], target_ff} - {pos_ff[POS_W-1], pos_ff};
         end
         PH_MHI: begin
            acc_in = prod_ext;
         end
         PH_MVB: begin
            acc_in = acc_ff + (prod_ext <<< FRAC_W);
         end
         PH_ACC: begin
            acc_in = acc_ff - (prod_ext <<< 1);
         end
         PH_CLA: begin
            // Bounds are whole multiples of 2^16, so clamp after the shift
            if (acc_sh > alim_s) begin
               a_in = $signed({1'b0, alim});
            end else if (acc_sh < -alim_s) begin
               a_in = -$signed({1'b0, alim});
            end else begin
               a_in = acc_sh[ACC_A_W-1:0];
            end
         end
         PH_VEL: begin
            if (vsum > vlim_s) begin
               vel_in = vlim_s[VEL_W-1:0];
            end else if (vsum < -vlim_s) begin
               vel_in = -vlim_s[VEL_W-1:0];
            end else begin
               vel_in = vsum[VEL_W-1:0];
            end
         end
         PH_POS: begin
            if (psum > $signed({{(PSUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}})) begin
               pos_in = {1'b0, {(POS_W-1){1'b1}}};
            end else if (psum < $signed({{(PSUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}})) begin
               pos_in = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
               pos_in = psum[POS_W-1:0];
            end
         end
         PH_LOAD: begin
            pos_in = target_ff;
            vel_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      err_ff    <= err_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
         pos_ff <= '0;
      end else begin
         vel_ff <= vel_in;
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// ===== design/tdx_ctrl.sv =====
// Item sequencer: handshake, phase stepping, bandwidth squared and result valid.
module tdx_ctrl
   import tdx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_load,
   input  logic [DT_W-1:0]  req_dt,
   input  logic [BW_W-1:0]  bw,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output lane_ctl_type     ctl,
   output logic [DT_W-1:0]  dt,
   output logic [BW2_W-1:0] bw2,
   output logic             out_load
);

   logic [PH_W-1:0]  state_ff, state_in;
   logic             init_ff, init_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DT_W-1:0]  dt_ff, dt_in;
   logic [BW2_W-1:0] bw2_ff, bw2_in;
   logic [2*BW_W-1:0] bw_sq;
   logic             accept;

   assign req_tready = (state_ff == PH_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = (state_ff == PH_OUT) && (!rsp_valid_ff || rsp_tready);
   assign bw_sq      = bw * bw;

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      dt_in        = accept ? req_dt : dt_ff;
      bw2_in       = (state_ff == PH_ERR) ? bw_sq[FRAC_W+BW2_W-1:FRAC_W] : bw2_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         PH_IDLE: begin
            if (accept) begin
               if (req_load || !init_ff) begin
                  state_in = PH_LOAD;
               end else if (req_dt == '0) begin
                  state_in = PH_OUT;
               end else begin
                  state_in = PH_ERR;
               end
            end
         end
         PH_ERR:  state_in = PH_MLO;
         PH_MLO:  state_in = PH_MHI;
         PH_MHI:  state_in = PH_MVB;
         PH_MVB:  state_in = PH_ACC;
         PH_ACC:  state_in = PH_CLA;
         PH_CLA:  state_in = PH_MAD;
         PH_MAD:  state_in = PH_VEL;
         PH_VEL:  state_in = PH_MVD;
         PH_MVD:  state_in = PH_POS;
         PH_POS:  state_in = PH_OUT;
         PH_LOAD: begin
            init_in  = 1'b1;
            state_in = PH_OUT;
         end
         PH_OUT: begin
            // Hold here until the output register is free
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = PH_IDLE;
            end
         end
         default: state_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_IDLE;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff  <= dt_in;
      bw2_ff <= bw2_in;
   end

   assign ctl.phase  = state_ff;
   assign ctl.take   = accept;
   assign dt         = dt_ff;
   assign bw2        = bw2_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_step_needs_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_ERR) |-> init_ff)
      else $error("filter step started before first load");

   a_load_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_LOAD) |=> (state_ff == PH_OUT && init_ff))
      else $error("load did not lead to result");

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == PH_OUT))
      else $error("result raised outside output phase");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != PH_IDLE))
      else $error("accepted word left sequencer idle");

endmodule

// ===== design/tracking_differentiator_3axis.sv =====
// Top level of the three-axis rate-limited tracking differentiator.
//
// Usage:
//   req_* : one word per update. req_tuser is the command (0 step toward
//           target, 1 load target), req_tdata carries the three Q15.16 targets
//           and the Q0.16 time step. A word is taken when req_tvalid and
//           req_tready are both high; req_tready is high only while idle.
//   rsp_* : one word per request word with the three smoothed positions.
//   csr_* : write enable, register index, data; write only while idle.
// A filter step runs every sequencer phase from error through position update,
//   a load (and the first word after reset, always a load) snaps to the target,
//   and a step with zero time step goes straight to the output phase.
// A new word is taken only once the previous one has reached the output register;
//   a filter step is the ten-phase sequence that each axis lane runs on its single
//   29x22 multiplier (error halves, bw * velocity, accel * dt, velocity * dt).
// The three lanes run in lockstep; the output register merges their
//   positions, so the next word is taken while a result still waits.
// Reset: clears the sequencer, the result valid, lane position and velocity
//   and restores register defaults. If rsp_tready is low, the finished word
//   holds in the output register and the next word stalls in its last phase.
module tracking_differentiator_3axis
   import tdx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // target_x, target_y, target_z, time_step
   input  logic                   req_tuser,   // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // ref_x, ref_y, ref_z
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [BW_W-1:0]       bw_ff, bw_in;
   logic [LIM_W-1:0]      alim_xy_ff, alim_xy_in;
   logic [LIM_W-1:0]      alim_z_ff, alim_z_in;
   logic [LIM_W-1:0]      vlim_xy_ff, vlim_xy_in;
   logic [LIM_W-1:0]      vlim_z_ff, vlim_z_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   lane_ctl_type     ctl;
   logic [DT_W-1:0]  dt;
   logic [BW2_W-1:0] bw2;
   logic             out_load;
   logic [POS_W-1:0] pos_x, pos_y, pos_z;

   // Configuration registers; writes to unused indexes drop
   always_comb begin
      bw_in      = bw_ff;
      alim_xy_in = alim_xy_ff;
      alim_z_in  = alim_z_ff;
      vlim_xy_in = vlim_xy_ff;
      vlim_z_in  = vlim_z_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BANDWIDTH: bw_in      = csr_wdata;
            CSR_ALIM_XY:   alim_xy_in = csr_wdata[LIM_W-1:0];
            CSR_ALIM_Z:    alim_z_in  = csr_wdata[LIM_W-1:0];
            CSR_VLIM_XY:   vlim_xy_in = csr_wdata[LIM_W-1:0];
            CSR_VLIM_Z:    vlim_z_in  = csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff      <= BW_RESET;
         alim_xy_ff <= ALIM_XY_RESET;
         alim_z_ff  <= ALIM_Z_RESET;
         vlim_xy_ff <= VLIM_XY_RESET;
         vlim_z_ff  <= VLIM_Z_RESET;
      end else begin
         bw_ff      <= bw_in;
         alim_xy_ff <= alim_xy_in;
         alim_z_ff  <= alim_z_in;
         vlim_xy_ff <= vlim_xy_in;
         vlim_z_ff  <= vlim_z_in;
      end
   end

   tdx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_load   (req_tuser),
      .req_dt     (req_tdata[DT_LSB+DT_W-1:DT_LSB]),
      .bw         (bw_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl),
      .dt         (dt),
      .bw2        (bw2),
      .out_load   (out_load)
   );

   tdx_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .target (req_tdata[POS_W-1:0]),
      .dt     (dt),
      .bw     (bw_ff),
      .bw2    (bw2),
      .alim   (alim_xy_ff),
      .vlim   (vlim_xy_ff),
      .pos    (pos_x)
   );

   tdx_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .target (req_tdata[2*POS_W-1:POS_W]),
      .dt     (dt),
      .bw     (bw_ff),
      .bw2    (bw2),
      .alim   (alim_xy_ff),
      .vlim   (vlim_xy_ff),
      .pos    (pos_y)
   );

   tdx_lane u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .target (req_tdata[3*POS_W-1:2*POS_W]),
      .dt     (dt),
      .bw     (bw_ff),
      .bw2    (bw2),
      .alim   (alim_z_ff),
      .vlim   (vlim_z_ff),
      .pos    (pos_z)
   );

   // Merge the lane positions into the output word
   assign rsp_data_in = out_load ? {pos_z, pos_y, pos_x} : rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== tb/tb_tracking_differentiator_3axis.sv =====
// Self-checking testbench for the three-axis tracking differentiator.
`timescale 1ns / 1ps

module tb_tracking_differentiator_3axis;
   import tdx_pkg::*;

   localparam int     RESET_CYCLES   = 11;
   localparam int     WATCHDOG_LIMIT = 4000;  // cycles with no word moved on any port
   localparam int     SETTLE_CYCLES  = 16;    // beyond the filter step latency
   localparam int     HOLDOFF_AT     = 300;   // result count that triggers the long stall
   localparam int     HOLDOFF_CYCLES = 400;
   localparam int     MAX_REPORTS    = 40;
   localparam int     PHASE_COUNT    = 8;
   localparam int     PHASE_WORDS    = 100;
   localparam int     CSR_PAD_W      = CSR_DATA_W - LIM_W;
   localparam logic   CMD_STEP       = 1'b0;
   localparam logic   CMD_LOAD       = 1'b1;
   localparam longint POS_LO         = -64'sd2147483648;
   localparam longint POS_HI         = 64'sd2147483647;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
   } position_set_type;

   typedef struct packed {
      logic             cmd;
      logic [POS_W-1:0] tx;
      logic [POS_W-1:0] ty;
      logic [POS_W-1:0] tz;
      logic [DT_W-1:0]  dt;
      logic             typed;   // expected positions given in the row itself
      logic [POS_W-1:0] ex;
      logic [POS_W-1:0] ey;
      logic [POS_W-1:0] ez;
   } directed_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // target_x, target_y, target_z, time_step
   logic                  req_tuser  = 1'b0; // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // ref_x, ref_y, ref_z
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Shadow of the block: registers, primed flag, per-axis position and velocity
   logic [BW_W-1:0]  model_bw      = BW_RESET;
   logic [LIM_W-1:0] model_alim_xy = ALIM_XY_RESET;
   logic [LIM_W-1:0] model_alim_z  = ALIM_Z_RESET;
   logic [LIM_W-1:0] model_vlim_xy = VLIM_XY_RESET;
   logic [LIM_W-1:0] model_vlim_z  = VLIM_Z_RESET;
   bit               model_primed  = 1'b0;
   longint           model_pos [3] = '{0, 0, 0};
   longint           model_vel [3] = '{0, 0, 0};

   position_set_type expected_positions [$];
   directed_row_type directed_rows [0:17];

   int  error_count   = 0;
   int  results_seen  = 0;
   int  idle_cycles   = 0;
   int  burst_left    = 0;
   bit  sender_gaps   = 1'b1;
   bit  holdoff_done  = 1'b0;

   tracking_differentiator_3axis dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic longint clamp64(input longint x, input longint lo, input longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // One filter step of one axis; every shift right floors, as the block does.
   function automatic void advance_axis_model(input int k, input longint target,
                                              input longint dt, input longint alim,
                                              input longint vlim);
      longint bw;
      longint bw_sq;
      longint accel;
      longint vel;
      longint pos;
      bw    = longint'(model_bw);
      bw_sq = (bw * bw) >>> FRAC_W;
      accel = bw_sq * (target - model_pos[k]) - 2 * bw * model_vel[k];
      accel = clamp64(accel, -(alim <<< FRAC_W), alim <<< FRAC_W) >>> FRAC_W;
      vel   = clamp64(model_vel[k] + ((accel * dt) >>> FRAC_W), -vlim, vlim);
      pos   = clamp64(model_pos[k] + ((vel * dt) >>> FRAC_W), POS_LO, POS_HI);
      model_vel[k] = vel;
      model_pos[k] = pos;
   endfunction

   // Apply one request word to the shadow state and return the positions it yields.
   function automatic position_set_type track_word(input logic cmd,
                                                   input logic [POS_W-1:0] tx,
                                                   input logic [POS_W-1:0] ty,
                                                   input logic [POS_W-1:0] tz,
                                                   input logic [DT_W-1:0] dt);
      longint           tgt [3];
      position_set_type result;
      tgt[0] = longint'($signed(tx));
      tgt[1] = longint'($signed(ty));
      tgt[2] = longint'($signed(tz));
      // A load, and the very first word after reset, snap straight to the target
      if (cmd == CMD_LOAD || !model_primed) begin
         model_primed = 1'b1;
         for (int k = 0; k < 3; k++) begin
            model_pos[k] = tgt[k];
            model_vel[k] = 0;
         end
      end else if (dt != '0) begin
         advance_axis_model(0, tgt[0], longint'(dt), longint'(model_alim_xy),
                            longint'(model_vlim_xy));
         advance_axis_model(1, tgt[1], longint'(dt), longint'(model_alim_xy),
                            longint'(model_vlim_xy));
         advance_axis_model(2, tgt[2], longint'(dt), longint'(model_alim_z),
                            longint'(model_vlim_z));
      end
      result.x = model_pos[0][POS_W-1:0];
      result.y = model_pos[1][POS_W-1:0];
      result.z = model_pos[2][POS_W-1:0];
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
                                  input logic [POS_W-1:0] want);
      if (error_count < MAX_REPORTS)
         $display("%0t ns: %s mismatch on result %0d: got %h, expected %h",
                  $time, what, results_seen, got, want);
      error_count++;
   endtask

   // Compare every accepted result word against the oldest pending expectation.
   always @(posedge clock) begin : check_results
      position_set_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_positions.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[POS_W-1:0], '0);
         end else begin
            want = expected_positions.pop_front();
            if (rsp_tdata[POS_W-1:0] !== want.x)
               report_mismatch("ref_x", rsp_tdata[POS_W-1:0], want.x);
            if (rsp_tdata[2*POS_W-1:POS_W] !== want.y)
               report_mismatch("ref_y", rsp_tdata[2*POS_W-1:POS_W], want.y);
            if (rsp_tdata[3*POS_W-1:2*POS_W] !== want.z)
               report_mismatch("ref_z", rsp_tdata[3*POS_W-1:2*POS_W], want.z);
         end
         results_seen++;
      end
   end

   // Watchdog: any word moving on any port restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d results pending",
                     idle_cycles, expected_positions.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: stall on a changing pattern, plus one long hold-off
   // ---------------------------------------------------------------------

   initial begin : result_sink
      int pattern;
      int run;
      int tick;
      tick = 0;
      @(negedge reset);
      forever begin
         pattern = $urandom_range(0, 3);
         run     = $urandom_range(16, 96);
         repeat (run) begin
            @(posedge clock);
            tick++;
            // Hold off long enough for the block to fill up and drop req_tready
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
               holdoff_done = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLDOFF_CYCLES) @(posedge clock);
            end else begin
               case (pattern)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= (tick % 4) != 0;
                  default: rsp_tready <= ($urandom_range(0, 4) == 0);
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one word, hold it until taken, then predict and either keep the burst going
   // or drop valid for a random gap.
   task automatic send_word(input logic cmd, input logic [POS_W-1:0] tx,
                            input logic [POS_W-1:0] ty, input logic [POS_W-1:0] tz,
                            input logic [DT_W-1:0] dt, input logic typed,
                            input position_set_type typed_set);
      position_set_type predicted;
      int               gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {dt, tz, ty, tx};
      do @(posedge clock); while (!req_tready);
      predicted = track_word(cmd, tx, ty, tz, dt);
      expected_positions.push_back(typed ? typed_set : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = sender_gaps ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid, wait for every pending result, then give the block time to go idle.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_BANDWIDTH: model_bw      = value[BW_W-1:0];
         CSR_ALIM_XY:   model_alim_xy = value[LIM_W-1:0];
         CSR_ALIM_Z:    model_alim_z  = value[LIM_W-1:0];
         CSR_VLIM_XY:   model_vlim_xy = value[LIM_W-1:0];
         CSR_VLIM_Z:    model_vlim_z  = value[LIM_W-1:0];
         default: ;     // unused index, write is dropped
      endcase
   endtask

   // Program all five registers; limit writes carry junk in the unused upper bits,
   // and an unused index gets a stray write first.
   task automatic program_settings(input logic [BW_W-1:0] bw, input logic [LIM_W-1:0] alim_xy,
                                   input logic [LIM_W-1:0] alim_z,
                                   input logic [LIM_W-1:0] vlim_xy,
                                   input logic [LIM_W-1:0] vlim_z);
      logic [CSR_IDX_W-1:0] unused_index;
      unused_index = CSR_IDX_W'($urandom_range(CSR_VLIM_Z + 1, (1 << CSR_IDX_W) - 1));
      write_register(unused_index, CSR_DATA_W'($urandom));
      write_register(CSR_BANDWIDTH, bw);
      write_register(CSR_ALIM_XY, {CSR_PAD_W'($urandom), alim_xy});
      write_register(CSR_ALIM_Z, {CSR_PAD_W'($urandom), alim_z});
      write_register(CSR_VLIM_XY, {CSR_PAD_W'($urandom), vlim_xy});
      write_register(CSR_VLIM_Z, {CSR_PAD_W'($urandom), vlim_z});
      csr_we <= 1'b0;
   endtask

   // Mostly steps toward targets near the current position so the filter actually tracks;
   // the rest are loads, full-range targets, targets at the range ends and odd time steps.
   task automatic random_words(input int count, input bit pause_midway);
      logic [POS_W-1:0] tgt [3];
      logic [DT_W-1:0]  dt;
      logic             cmd;
      int               sel;
      int unsigned      offset;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2)
            settle_block();
         cmd = ($urandom_range(0, 19) == 0) ? CMD_LOAD : CMD_STEP;
         for (int k = 0; k < 3; k++) begin
            sel    = $urandom_range(0, 9);
            offset = $urandom_range(0, 32'h0020_0000);
            if (sel < 6)
               tgt[k] = POS_W'(model_pos[k] + longint'(offset) - 64'sd1048576);
            else if (sel < 8)
               tgt[k] = $urandom;
            else if (sel == 8)
               tgt[k] = 32'h7FFF_FFFF - $urandom_range(0, 255);
            else
               tgt[k] = 32'h8000_0000 + $urandom_range(0, 255);
         end
         sel = $urandom_range(0, 9);
         case (sel)
            0: dt = '0;
            1: dt = '1;
            2: dt = DT_W'($urandom_range(1, 16));
            3: dt = DT_W'($urandom_range(0, 65535));
            default: dt = DT_W'($urandom_range(1000, 4000));
         endcase
         send_word(cmd, tgt[0], tgt[1], tgt[2], dt, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin : stimulus
      position_set_type typed_set;
      logic [BW_W-1:0]  bw;
      logic [LIM_W-1:0] lim [4];

      // cmd, target x/y/z, time step, typed, expected x/y/z
      directed_rows = '{
         // first word after reset acts as a load even as a step
         '{CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'd1234,
           1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
         // zero time step holds the stored positions
         '{CMD_STEP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 16'h0000,
           1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
         '{CMD_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF,
           1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
         // small moves at a 30 Hz tick, then at the largest and smallest time step
         '{CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000, 16'd2184, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000, 16'd2184, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000, 16'd2184, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000, 16'd2184, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000, 16'hFFFF, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000, 16'h0001, 1'b0, '0, '0, '0},
         // far targets at the range ends: acceleration and velocity clamp
         '{CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0, '0, '0, '0},
         '{CMD_LOAD, 32'h7FFF_FF00, 32'h8000_0100, 32'h7FFF_FFFF, 16'h0000,
           1'b1, 32'h7FFF_FF00, 32'h8000_0100, 32'h7FFF_FFFF},
         // overshoot past the range ends saturates the position
         '{CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0, '0, '0},
         '{CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000,
           1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
         '{CMD_STEP, 32'hFFFF_FFFE, 32'h0000_0001, 32'h5555_5555, 16'hAAAA, 1'b0, '0, '0, '0},
         '{CMD_STEP, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 16'h5555, 1'b0, '0, '0, '0},
         '{CMD_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8000,
           1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}
      };

      // Hold reset, then release it at a rising edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset register values
      foreach (directed_rows[i]) begin
         typed_set.x = directed_rows[i].ex;
         typed_set.y = directed_rows[i].ey;
         typed_set.z = directed_rows[i].ez;
         send_word(directed_rows[i].cmd, directed_rows[i].tx, directed_rows[i].ty,
                   directed_rows[i].tz, directed_rows[i].dt, directed_rows[i].typed,
                   typed_set);
      end

      // Random phases, each with its own register setting written while idle
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_block();
         case (phase)
            0: begin
               // zero limits: no acceleration, velocity pinned at zero
               bw = '0;
               lim = '{'0, '0, '0, '0};
            end
            1: begin
               bw = '1;
               lim = '{'1, '1, '1, '1};
            end
            2: begin
               bw = BW_RESET;
               lim = '{ALIM_XY_RESET, ALIM_Z_RESET, VLIM_XY_RESET, VLIM_Z_RESET};
            end
            3: begin
               // xy frozen by its acceleration limit, z by its velocity limit
               bw = BW_W'(2 << FRAC_W);
               lim = '{'0, '1, '1, '0};
            end
            4: begin
               bw = BW_W'($urandom_range(0, (1 << BW_W) - 1));
               for (int k = 0; k < 4; k++) lim[k] = LIM_W'($urandom);
            end
            7: begin
               bw = '1;
               for (int k = 0; k < 4; k++) lim[k] = LIM_W'($urandom_range(1, 8192));
            end
            default: begin
               bw = BW_W'($urandom_range(0, 20 << FRAC_W));
               for (int k = 0; k < 4; k++) lim[k] = LIM_W'($urandom_range(0, 16 << FRAC_W));
            end
         endcase
         program_settings(bw, lim[0], lim[1], lim[2], lim[3]);
         // phase 2 runs the sender without gaps and pauses it halfway until drained
         sender_gaps = (phase != 2);
         random_words(PHASE_WORDS, phase == 2);
      end

      settle_block();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tdx_pkg.sv
design/tdx_lane.sv
design/tdx_ctrl.sv
design/tracking_differentiator_3axis.sv
tb/tb_tracking_differentiator_3axis.sv
